FILE: design/bvhsl_pkg.sv
`timescale 1ns / 1ps
package bvhsl_pkg;
  localparam int NODE_DEPTH = 1024;
  localparam int MAX_HITS   = 64;
  localparam int AW         = $clog2(NODE_DEPTH);
  // walk pointer has headroom for pointer plus skip
  localparam int PW         = AW + 2;
  // node word: lo x,y,z, hi x,y,z, skip, leaf
  localparam int NODE_W     = 6 * 32 + 11 + 1;
  localparam int SKIP_LSB   = 192;
  localparam int LEAF_BIT   = 203;
  localparam int SHORT_SQ   = 43;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_BOX   = 2'd1;
  localparam logic [1:0] REQ_RAY   = 2'd2;

  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_MAX_LEAFS  = 1'b1;
endpackage

FILE: design/bvhsl_ram.sv
`timescale 1ns / 1ps
module bvhsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: design/bvh_skiplist_overlap_query.sv
`timescale 1ns / 1ps
// write word: taken when idle, no result
// box query: each visited node steps through read, evaluate and decide, between start and finish
// ray query: same node states; a node inside the slab bounds adds a multiply and a compare
// state per index pair (one pair of 33x33 products each), ending at the first failing pair
// reset (rst_ni low, async): control idle, node_count 0, max_leafs 64; node memory not cleared
module bvh_skiplist_overlap_query
  import bvhsl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // node_index, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, subtree_size, leaf_flag
  input  logic [215:0] s_axis_tdata,
  // req_type
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // leaf_node
  output logic [15:0]  m_axis_tdata,
  // found
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_RD, ST_EVAL, ST_MUL, ST_CMP, ST_DECIDE, ST_FINISH
  } state_e;

  state_e state_q;

  logic [10:0] node_count_q;
  logic [6:0]  max_leafs_q;

  logic               in_acc;
  logic [NODE_W-1:0]  rdata;
  logic               is_ray_q;
  logic signed [31:0] qlo_q [3];
  logic signed [31:0] qhi_q [3];
  logic signed [32:0] d_q   [3];
  logic [31:0]        dd_q  [3];
  logic [10:0]        count_q;
  logic [6:0]         limit_q;
  logic [PW-1:0]      ptr_q;
  logic [6:0]         cnt_q;
  logic               pend_v_q;
  logic [AW-1:0]      pend_q;
  logic signed [32:0] en_q [3];
  logic signed [32:0] ex_q [3];
  logic [2:0]         act_q;
  logic               hit_q;
  logic               leaf_q;
  logic [10:0]        skip_q;
  logic [1:0]         pi_q, pj_q;
  logic signed [65:0] p1_q, p2_q;
  logic               pact_q;
  logic               mv_q;
  logic [AW-1:0]      mleaf_q;
  logic               mfound_q, mlast_q;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign pready        = 1'b1;
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = {{(16-AW){1'b0}}, mleaf_q};
  assign m_axis_tuser  = mfound_q;
  assign m_axis_tlast  = mlast_q;
  assign prdata = (paddr[2] == REG_MAX_LEAFS) ? {25'd0, max_leafs_q} : {21'd0, node_count_q};

  // node store, written straight from the input word
  bvhsl_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_nodes (
    .clk_i   (clk_i),
    .we_i    (in_acc && (s_axis_tuser == REQ_WRITE)),
    .waddr_i (s_axis_tdata[AW-1:0]),
    .wdata_i (s_axis_tdata[10 +: NODE_W]),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // query setup: direction and short ray test
  logic signed [32:0] dir   [3];
  logic [31:0]        dmag  [3];
  logic               small_ray;
  logic [7:0]         s2;
  always_comb begin
    small_ray = 1'b1;
    s2 = 8'd0;
    for (int k = 0; k < 3; k++) begin
      dir[k]  = {qhi_q[k][31], qhi_q[k]} - {qlo_q[k][31], qlo_q[k]};
      dmag[k] = dir[k][32] ? 32'(-dir[k]) : dir[k][31:0];
      if (dmag[k] >= 32'd8) small_ray = 1'b0;
      s2 = s2 + 8'({5'd0, dmag[k][2:0]} * {5'd0, dmag[k][2:0]});
    end
  end

  // node evaluation: box test and ray slab bounds
  logic signed [31:0] nlo [3];
  logic signed [31:0] nhi [3];
  logic signed [32:0] na  [3];
  logic signed [32:0] nb  [3];
  logic signed [32:0] en_c [3];
  logic signed [32:0] ex_c [3];
  logic [2:0]         act_c;
  logic               box_hit, ray_pre;
  always_comb begin
    box_hit = 1'b1;
    ray_pre = 1'b1;
    for (int k = 0; k < 3; k++) begin
      nlo[k] = rdata[32*k +: 32];
      nhi[k] = rdata[96 + 32*k +: 32];
      if (qlo_q[k] > nhi[k] || nlo[k] > qhi_q[k]) box_hit = 1'b0;
      na[k] = {nlo[k][31], nlo[k]} - {qlo_q[k][31], qlo_q[k]};
      nb[k] = {nhi[k][31], nhi[k]} - {qlo_q[k][31], qlo_q[k]};
      if (d_q[k][32]) begin
        na[k] = -na[k];
        nb[k] = -nb[k];
      end
      en_c[k]  = (na[k] < nb[k]) ? na[k] : nb[k];
      ex_c[k]  = (na[k] < nb[k]) ? nb[k] : na[k];
      act_c[k] = (d_q[k] != 33'sd0);
      if (!act_c[k] && (en_c[k] > 33'sd0 || ex_c[k] < 33'sd0)) ray_pre = 1'b0;
      if (act_c[k] && (ex_c[k] < 33'sd0 || en_c[k] > $signed({1'b0, dd_q[k]}))) ray_pre = 1'b0;
    end
  end

  // pairwise products en_i*dd_j and ex_j*dd_i
  logic signed [65:0] p1_c, p2_c;
  assign p1_c = en_q[pi_q] * $signed({1'b0, dd_q[pj_q]});
  assign p2_c = ex_q[pj_q] * $signed({1'b0, dd_q[pi_q]});

  // walk step
  logic [PW-1:0] step, ptr_nx;
  logic          out_free, cnt_full;
  assign step     = (hit_q || leaf_q || skip_q == 11'd0) ? PW'(1) : PW'(skip_q);
  assign ptr_nx   = ptr_q + step;
  assign out_free = !mv_q || m_axis_tready;
  assign cnt_full = ({1'b0, cnt_q} + 8'd1) >= {1'b0, limit_q};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 11'd0;
      max_leafs_q  <= 7'd64;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_NODE_COUNT) node_count_q <= pwdata[10:0];
      else                            max_leafs_q  <= pwdata[6:0];
    end
  end

  // query payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < 3; k++) begin
        qlo_q[k] <= s_axis_tdata[10 + 32*k +: 32];
        qhi_q[k] <= s_axis_tdata[106 + 32*k +: 32];
      end
    end
  end

  // walk sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mv_q     <= 1'b0;
      pend_v_q <= 1'b0;
      cnt_q    <= 7'd0;
      ptr_q    <= '0;
      is_ray_q <= 1'b0;
      pi_q     <= 2'd0;
      pj_q     <= 2'd0;
    end else begin
      if (mv_q && m_axis_tready) mv_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && (s_axis_tuser == REQ_BOX || s_axis_tuser == REQ_RAY)) begin
            is_ray_q <= (s_axis_tuser == REQ_RAY);
            state_q  <= ST_START;
          end
        end
        ST_START: begin
          for (int k = 0; k < 3; k++) begin
            d_q[k]  <= dir[k];
            dd_q[k] <= dmag[k];
          end
          count_q  <= (node_count_q > 11'(NODE_DEPTH)) ? 11'(NODE_DEPTH) : node_count_q;
          limit_q  <= (max_leafs_q > 7'(MAX_HITS)) ? 7'(MAX_HITS) : max_leafs_q;
          cnt_q    <= 7'd0;
          pend_v_q <= 1'b0;
          ptr_q    <= '0;
          if (max_leafs_q == 7'd0 || node_count_q == 11'd0 ||
              (is_ray_q && small_ray && s2 < 8'(SHORT_SQ))) state_q <= ST_FINISH;
          else state_q <= ST_RD;
        end
        ST_RD: state_q <= ST_EVAL;
        ST_EVAL: begin
          leaf_q <= rdata[LEAF_BIT];
          skip_q <= rdata[SKIP_LSB +: 11];
          for (int k = 0; k < 3; k++) begin
            en_q[k] <= en_c[k];
            ex_q[k] <= ex_c[k];
          end
          act_q <= act_c;
          pi_q  <= 2'd0;
          pj_q  <= 2'd0;
          if (!is_ray_q) begin
            hit_q   <= box_hit;
            state_q <= ST_DECIDE;
          end else begin
            hit_q   <= ray_pre;
            state_q <= ray_pre ? ST_MUL : ST_DECIDE;
          end
        end
        ST_MUL: begin
          p1_q    <= p1_c;
          p2_q    <= p2_c;
          pact_q  <= act_q[pi_q] && act_q[pj_q];
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (pact_q && p1_q > p2_q) begin
            hit_q   <= 1'b0;
            state_q <= ST_DECIDE;
          end else if (pi_q == 2'd2 && pj_q == 2'd2) begin
            state_q <= ST_DECIDE;
          end else begin
            if (pj_q == 2'd2) begin
              pj_q <= 2'd0;
              pi_q <= pi_q + 2'd1;
            end else begin
              pj_q <= pj_q + 2'd1;
            end
            state_q <= ST_MUL;
          end
        end
        ST_DECIDE: begin
          if (leaf_q && hit_q) begin
            if (!pend_v_q || out_free) begin
              if (pend_v_q) begin
                mv_q     <= 1'b1;
                mfound_q <= 1'b1;
                mleaf_q  <= pend_q;
                mlast_q  <= 1'b0;
              end
              pend_v_q <= 1'b1;
              pend_q   <= ptr_q[AW-1:0];
              cnt_q    <= cnt_q + 7'd1;
              if (cnt_full || ptr_nx >= {1'b0, count_q}) state_q <= ST_FINISH;
              else begin
                ptr_q   <= ptr_nx;
                state_q <= ST_RD;
              end
            end
          end else if (ptr_nx >= {1'b0, count_q}) begin
            state_q <= ST_FINISH;
          end else begin
            ptr_q   <= ptr_nx;
            state_q <= ST_RD;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            mv_q     <= 1'b1;
            mfound_q <= pend_v_q;
            mleaf_q  <= pend_v_q ? pend_q : '0;
            mlast_q  <= 1'b1;
            pend_v_q <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

FILE: design/bvhsl_checker.sv
`timescale 1ns / 1ps
module bvhsl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);
  // an empty query word is always the last of its query
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("empty result without last");

  // an empty query word carries leaf index zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 16'd0))
    else $error("empty result with nonzero index");

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");
endmodule

bind bvh_skiplist_overlap_query bvhsl_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
